// ----- design/itaf_pkg.sv -----
package itaf_pkg;

   // Field widths of the transfers
   localparam int VALUE_IN_BITS = 64;
   localparam int WIDTH_BITS    = 6;
   localparam int BASE_BITS     = 2;
   localparam int CHAR_BITS     = 8;
   localparam int REQ_DATA_BITS = ((VALUE_IN_BITS + WIDTH_BITS + 7) / 8) * 8;
   localparam int REQ_USER_BITS = BASE_BITS + 1;

   // Number format
   localparam int VALUE_BITS = 64;
   localparam int MAX_WIDTH  = 63;

   // Digit slots needed for a VALUE_BITS-bit magnitude in each radix
   localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
   localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int MAX_DIGITS = OCT_DIGITS;
   localparam int ACC_BITS   = 4 * DEC_DIGITS;
   localparam int OCT_TOP    = 3 * OCT_DIGITS - 1;
   localparam int HEX_TOP    = 4 * HEX_DIGITS - 1;

   localparam int POS_BITS = $clog2(MAX_DIGITS + 1);
   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam int CMP_BITS = (WIDTH_BITS > POS_BITS) ? WIDTH_BITS : POS_BITS;

   // Radix codes
   localparam logic [BASE_BITS-1:0] BASE_OCT = 2'd0;
   localparam logic [BASE_BITS-1:0] BASE_DEC = 2'd1;
   localparam logic [BASE_BITS-1:0] BASE_HEX = 2'd2;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [CHAR_BITS-1:0] DIGIT_SET [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   // Commands from the sequencer to the digit unit
   typedef struct packed {
      logic                 load;
      logic                 negate;
      logic                 step;
      logic                 shift;
      logic [BASE_BITS-1:0] base;
   } conv_cmd_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] digit);
      return DIGIT_SET[digit];
   endfunction

endpackage

// ----- design/itaf_conv.sv -----
// Digit unit: magnitude shift register feeding a digit accumulator one bit
// per cycle (shift-add-3 for decimal, plain shift for octal and hex), then
// shifting whole digits out of the top window.
module itaf_conv (
   input  logic                                 clock,
   input  itaf_pkg::conv_cmd_type               cmd,
   input  logic [itaf_pkg::VALUE_IN_BITS-1:0]   load_value,
   output logic [3:0]                           top_digit
);

   logic [itaf_pkg::VALUE_BITS-1:0] mag_ff;
   logic [itaf_pkg::VALUE_BITS-1:0] mag_in;
   logic [itaf_pkg::ACC_BITS-1:0]   acc_ff;
   logic [itaf_pkg::ACC_BITS-1:0]   acc_in;
   logic [itaf_pkg::ACC_BITS-1:0]   acc_fix;
   logic [itaf_pkg::VALUE_BITS-1:0] raw;

   always_comb begin
      raw     = load_value[itaf_pkg::VALUE_BITS-1:0];
      mag_in  = mag_ff;
      acc_in  = acc_ff;
      acc_fix = acc_ff;
      if (cmd.load) begin
         mag_in = cmd.negate ? (~raw + 1'b1) : raw;
         acc_in = '0;
      end else if (cmd.step) begin
         // Correct each BCD digit before the doubling shift
         if (cmd.base == itaf_pkg::BASE_DEC) begin
            for (int d = 0; d < itaf_pkg::DEC_DIGITS; d++) begin
               if (acc_ff[4*d +: 4] >= 4'd5) begin
                  acc_fix[4*d +: 4] = acc_ff[4*d +: 4] + 4'd3;
               end
            end
         end
         acc_in = {acc_fix[itaf_pkg::ACC_BITS-2:0], mag_ff[itaf_pkg::VALUE_BITS-1]};
         mag_in = {mag_ff[itaf_pkg::VALUE_BITS-2:0], 1'b0};
      end else if (cmd.shift) begin
         acc_in = (cmd.base == itaf_pkg::BASE_OCT) ? (acc_ff << 3) : (acc_ff << 4);
      end
   end

   always_comb begin
      case (cmd.base)
         itaf_pkg::BASE_OCT: top_digit = {1'b0, acc_ff[itaf_pkg::OCT_TOP -: 3]};
         itaf_pkg::BASE_DEC: top_digit = acc_ff[itaf_pkg::ACC_BITS-1 -: 4];
         default:            top_digit = acc_ff[itaf_pkg::HEX_TOP -: 4];
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      acc_ff <= acc_in;
   end

endmodule

// ----- design/integer_to_ascii_formatter.sv -----
// Integer to ASCII formatter. Each request transfer carries one number; the
// block answers with its characters, most significant first, uppercase
// digits, an optional leading '-', zero padding up to min_width digits (the
// sign not counted, width limited to 63), and rsp_tlast on the final
// character. One number at a time: after the request transfer the magnitude
// is shifted into the digit accumulator one bit per cycle, with shift-add-3
// correction in decimal, then leading zero digits are dropped one per cycle,
// then the characters leave the output register one per cycle while the
// receiver accepts them. A finished character waits in the output register
// while the next one is prepared.
module integer_to_ascii_formatter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // value [63:0], min_width [69:64], zero fill above
   input  logic [itaf_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // base_code [1:0], is_signed [2]
   input  logic [itaf_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_char [7:0]
   output logic [itaf_pkg::CHAR_BITS-1:0]       rsp_tdata,
   output logic                                 rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_SIGN,
      ST_PAD,
      ST_DIGIT
   } state_type;

   state_type                          state_ff, state_in;
   logic                               neg_ff, neg_in;
   logic [itaf_pkg::BASE_BITS-1:0]     base_ff, base_in;
   logic [itaf_pkg::WIDTH_BITS-1:0]    width_ff, width_in;
   logic [itaf_pkg::WIDTH_BITS-1:0]    pad_ff, pad_in;
   logic [itaf_pkg::POS_BITS-1:0]      pos_ff, pos_in;
   logic [itaf_pkg::CNT_BITS-1:0]      bit_cnt_ff, bit_cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [itaf_pkg::CHAR_BITS-1:0]     rsp_char_ff, rsp_char_in;
   logic                               rsp_last_ff, rsp_last_in;

   itaf_pkg::conv_cmd_type             cmd;
   logic [3:0]                         top_digit;
   logic                               out_free;
   logic [itaf_pkg::VALUE_IN_BITS-1:0] req_value;
   logic [itaf_pkg::WIDTH_BITS-1:0]    req_width;
   logic [itaf_pkg::BASE_BITS-1:0]     req_base;
   logic                               req_signed;
   logic [itaf_pkg::POS_BITS-1:0]      slots;
   logic [itaf_pkg::WIDTH_BITS-1:0]    pad_calc;

   assign req_value  = req_tdata[itaf_pkg::VALUE_IN_BITS-1:0];
   assign req_width  = req_tdata[itaf_pkg::VALUE_IN_BITS +: itaf_pkg::WIDTH_BITS];
   assign req_base   = req_tuser[itaf_pkg::BASE_BITS-1:0];
   assign req_signed = req_tuser[itaf_pkg::BASE_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Output register can take a new character when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Digit slots the accumulator holds for the current radix
   always_comb begin
      case (base_ff)
         itaf_pkg::BASE_OCT: slots = itaf_pkg::POS_BITS'(itaf_pkg::OCT_DIGITS);
         itaf_pkg::BASE_DEC: slots = itaf_pkg::POS_BITS'(itaf_pkg::DEC_DIGITS);
         default:            slots = itaf_pkg::POS_BITS'(itaf_pkg::HEX_DIGITS);
      endcase
   end

   // Zeros owed in front of the significant digits
   assign pad_calc = (itaf_pkg::CMP_BITS'(width_ff) > itaf_pkg::CMP_BITS'(pos_ff)) ?
                     itaf_pkg::WIDTH_BITS'(itaf_pkg::CMP_BITS'(width_ff) -
                                           itaf_pkg::CMP_BITS'(pos_ff)) : '0;

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      width_in     = width_ff;
      pad_in       = pad_ff;
      pos_in       = pos_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      cmd          = '0;
      cmd.base     = base_ff;

      // Drop the character once its transfer completes
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load   = 1'b1;
               cmd.negate = req_signed && req_value[itaf_pkg::VALUE_BITS-1];
               neg_in     = cmd.negate;
               // Unused radix code falls back to hex
               base_in    = (req_base == itaf_pkg::BASE_OCT ||
                             req_base == itaf_pkg::BASE_DEC) ? req_base : itaf_pkg::BASE_HEX;
               width_in   = (req_width > itaf_pkg::WIDTH_BITS'(itaf_pkg::MAX_WIDTH)) ?
                            itaf_pkg::WIDTH_BITS'(itaf_pkg::MAX_WIDTH) : req_width;
               bit_cnt_in = itaf_pkg::CNT_BITS'(itaf_pkg::VALUE_BITS - 1);
               state_in   = ST_CONV;
            end
         end

         ST_CONV: begin
            cmd.step = 1'b1;
            if (bit_cnt_ff == '0) begin
               pos_in   = slots;
               state_in = ST_TRIM;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end

         ST_TRIM: begin
            // Strip leading zero digits, keeping at least one
            if (top_digit == 4'd0 && pos_ff > itaf_pkg::POS_BITS'(1)) begin
               cmd.shift = 1'b1;
               pos_in    = pos_ff - 1'b1;
            end else begin
               pad_in = pad_calc;
               if (neg_ff) begin
                  state_in = ST_SIGN;
               end else if (pad_calc != '0) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end

         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itaf_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = (pad_ff != '0) ? ST_PAD : ST_DIGIT;
            end
         end

         ST_PAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itaf_pkg::CHAR_ZERO;
               rsp_last_in  = 1'b0;
               pad_in       = pad_ff - 1'b1;
               if (pad_ff == itaf_pkg::WIDTH_BITS'(1)) begin
                  state_in = ST_DIGIT;
               end
            end
         end

         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itaf_pkg::digit_char(top_digit);
               rsp_last_in  = (pos_ff == itaf_pkg::POS_BITS'(1));
               cmd.shift    = 1'b1;
               pos_in       = pos_ff - 1'b1;
               if (pos_ff == itaf_pkg::POS_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      width_ff    <= width_in;
      pad_ff      <= pad_in;
      pos_ff      <= pos_in;
      bit_cnt_ff  <= bit_cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   itaf_conv u_conv (
      .clock      (clock),
      .cmd        (cmd),
      .load_value (req_value),
      .top_digit  (top_digit)
   );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

   // Code 3 is outside the named radix set and must format as hexadecimal
   localparam logic [itaf_pkg::BASE_BITS-1:0] BASE_SPARE = 2'd3;

   localparam int RANDOM_NUMBERS = 256;
   localparam int QUIET_NUMBERS  = 40;   // closing stretch with no idling
   localparam int DRAIN_CYCLES   = 200;  // longer than one number takes

   // One character as it leaves the block
   typedef struct packed {
      logic [itaf_pkg::CHAR_BITS-1:0] ch;
      logic                           last;
   } char_xfer_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   // value [63:0], min_width [69:64], zero fill above
   logic [itaf_pkg::REQ_DATA_BITS-1:0] req_tdata;
   // base_code [1:0], is_signed [2]
   logic [itaf_pkg::REQ_USER_BITS-1:0] req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   // out_char [7:0]
   logic [itaf_pkg::CHAR_BITS-1:0]     rsp_tdata;
   logic                               rsp_tlast;

   char_xfer_type expected_chars [$];

   // Directed stimulus rows; an empty text means the predictor supplies the answer
   logic [63:0]                    row_value [$];
   logic [itaf_pkg::BASE_BITS-1:0] row_base  [$];
   logic                           row_sgn   [$];
   logic [5:0]                     row_width [$];
   string                          row_text  [$];

   int  fail_count   = 0;
   int  numbers_sent = 0;
   int  chars_seen   = 0;
   bit  quiet_tail   = 1'b0;
   int  stall_left   = 0;

   integer_to_ascii_formatter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void push_char(input logic [itaf_pkg::CHAR_BITS-1:0] ch,
                                     input logic last);
      char_xfer_type x;
      x.ch   = ch;
      x.last = last;
      expected_chars.push_back(x);
   endfunction

   // Queue a hand-written answer; the final character carries the last flag
   function automatic void queue_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         push_char(text[i], i == text.len() - 1);
      end
   endfunction

   // Work out the characters of one number and queue them in output order
   function automatic void format_number(input logic [63:0] value,
                                         input logic [itaf_pkg::BASE_BITS-1:0] base,
                                         input logic sgn,
                                         input logic [5:0] width);
      logic [63:0]                    mag;
      logic [63:0]                    radix;
      logic [63:0]                    rem;
      logic [itaf_pkg::CHAR_BITS-1:0] digs [64];
      int                             nd;
      int                             total;
      int                             lim;
      int                             n_out;
      int                             k;
      bit                             neg;
      if (base == itaf_pkg::BASE_OCT) radix = 64'd8;
      else if (base == itaf_pkg::BASE_DEC) radix = 64'd10;
      else radix = 64'd16;
      neg = sgn && value[63];
      // The most negative value wraps back onto itself here, which is intended
      mag = neg ? (~value + 64'd1) : value;
      nd  = 0;
      do begin
         rem      = mag % radix;
         digs[nd] = itaf_pkg::DIGIT_SET[rem[3:0]];
         nd++;
         mag      = mag / radix;
      end while (mag != 64'd0 && nd < 64);
      lim   = (int'(width) > itaf_pkg::MAX_WIDTH) ? itaf_pkg::MAX_WIDTH : int'(width);
      total = (nd > lim) ? nd : lim;
      n_out = total + (neg ? 1 : 0);
      k     = 0;
      if (neg) begin
         k++;
         push_char(itaf_pkg::CHAR_MINUS, k == n_out);
      end
      for (int i = nd; i < total; i++) begin
         k++;
         push_char(itaf_pkg::CHAR_ZERO, k == n_out);
      end
      for (int i = nd; i > 0; i--) begin
         k++;
         push_char(digs[i-1], k == n_out);
      end
   endfunction

   task automatic add_row(input logic [63:0] value,
                          input logic [itaf_pkg::BASE_BITS-1:0] base,
                          input logic sgn, input logic [5:0] width, input string text);
      row_value.push_back(value);
      row_base.push_back(base);
      row_sgn.push_back(sgn);
      row_width.push_back(width);
      row_text.push_back(text);
   endtask

   // Offer one number on the request side, with an optional idle burst first,
   // and queue its answer once the transfer has been taken
   task automatic send_number(input logic [63:0] value,
                              input logic [itaf_pkg::BASE_BITS-1:0] base,
                              input logic sgn, input logic [5:0] width, input string text);
      int gap;
      gap = 0;
      if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, width, value};
      req_tuser  <= {sgn, base};
      // hold the transfer until the block takes it
      do @(posedge clock); while (!req_tready);
      if (text.len() == 0) format_number(value, base, sgn, width);
      else queue_text(text);
      numbers_sent++;
   endtask

   // Mix of full-range, small, shifted, negative and corner values
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = 64'($urandom_range(0, 20));
         2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         3: v = ~64'($urandom_range(0, 300)) + 64'd1;
         4: begin
            case ($urandom_range(0, 4))
               0: v = 64'd0;
               1: v = {64{1'b1}};
               2: v = {1'b1, 63'd0};
               3: v = {1'b0, {63{1'b1}}};
               default: v = 64'd1 << $urandom_range(0, 63);
            endcase
         end
         default: v = 64'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [5:0] random_width();
      case ($urandom_range(0, 7))
         0: return 6'($urandom_range(0, 63));
         1: return 6'd63;
         default: return 6'($urandom_range(0, 8));
      endcase
   endfunction

   // Receiver side: stall in random bursts, never during the closing stretch
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!quiet_tail && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 10);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // Check every character transfer against the oldest pending expectation
   always @(posedge clock) begin
      char_xfer_type x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         chars_seen++;
         if (expected_chars.size() == 0) begin
            $error("unexpected character transfer: out_char 0x%02h last %0b",
                   rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            x = expected_chars.pop_front();
            if (rsp_tdata !== x.ch) begin
               $error("out_char: expected 0x%02h, got 0x%02h", x.ch, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== x.last) begin
               $error("last: expected %0b, got %0b", x.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      logic [63:0] v;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero in every radix, with and without padding
      add_row(64'd0, itaf_pkg::BASE_DEC, 1'b0, 6'd0, "0");
      add_row(64'd0, itaf_pkg::BASE_HEX, 1'b1, 6'd0, "0");
      add_row(64'd0, itaf_pkg::BASE_OCT, 1'b0, 6'd5, "00000");
      add_row(64'd0, itaf_pkg::BASE_DEC, 1'b0, 6'd63, "");
      // All ones, unsigned then signed
      add_row({64{1'b1}}, itaf_pkg::BASE_HEX, 1'b0, 6'd0, "FFFFFFFFFFFFFFFF");
      add_row({64{1'b1}}, itaf_pkg::BASE_DEC, 1'b0, 6'd0, "18446744073709551615");
      add_row({64{1'b1}}, itaf_pkg::BASE_OCT, 1'b0, 6'd0,
              {"1", "7777777", "7777777", "7777777"});
      add_row({64{1'b1}}, itaf_pkg::BASE_DEC, 1'b1, 6'd0, "-1");
      // Most negative value keeps its unsigned magnitude
      add_row({1'b1, 63'd0}, itaf_pkg::BASE_DEC, 1'b1, 6'd0, "-9223372036854775808");
      add_row({1'b1, 63'd0}, itaf_pkg::BASE_HEX, 1'b1, 6'd0, "-8000000000000000");
      add_row({1'b1, 63'd0}, itaf_pkg::BASE_OCT, 1'b1, 6'd0,
              {"-1", "0000000", "0000000", "0000000"});
      add_row({1'b0, {63{1'b1}}}, itaf_pkg::BASE_DEC, 1'b1, 6'd0, "9223372036854775807");
      // Spare radix code behaves as hex
      add_row(64'd255, BASE_SPARE, 1'b0, 6'd0, "FF");
      add_row(64'hFFFF_FFFF_FFFF_FF00, BASE_SPARE, 1'b1, 6'd2, "");
      // Padding does not count the sign, and never truncates
      add_row(64'hFFFF_FFFF_FFFF_FFFB, itaf_pkg::BASE_DEC, 1'b1, 6'd4, "-0005");
      add_row(64'd12345, itaf_pkg::BASE_DEC, 1'b0, 6'd3, "12345");
      add_row({64{1'b1}}, itaf_pkg::BASE_HEX, 1'b1, 6'd63, "");
      add_row(64'd1, itaf_pkg::BASE_OCT, 1'b1, 6'd63, "");
      add_row({64{1'b1}}, itaf_pkg::BASE_OCT, 1'b1, 6'd63, "");
      // Plain values
      add_row(64'hDEAD_BEEF, itaf_pkg::BASE_HEX, 1'b0, 6'd0, "DEADBEEF");
      add_row(64'd8, itaf_pkg::BASE_OCT, 1'b0, 6'd0, "10");
      add_row(64'd10, itaf_pkg::BASE_DEC, 1'b1, 6'd0, "10");
      add_row(64'hABCD_EF01_2345_6789, itaf_pkg::BASE_HEX, 1'b1, 6'd0, "");
      add_row(64'hFEDC_BA98_7654_3210, itaf_pkg::BASE_DEC, 1'b0, 6'd21, "");

      for (int i = 0; i < row_value.size(); i++) begin
         send_number(row_value[i], row_base[i], row_sgn[i], row_width[i], row_text[i]);
      end

      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         if (i >= RANDOM_NUMBERS - QUIET_NUMBERS) quiet_tail = 1'b1;
         v = random_value();
         send_number(v, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     random_width(), "");
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain what is still owed, then watch for stray characters
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d numbers in all four radix codes, signed and unsigned, widths 0-63;",
               numbers_sent);
      $display("checked %0d character transfers under random idling on both sides.",
               chars_seen);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
design/itaf_pkg.sv
design/itaf_conv.sv
design/integer_to_ascii_formatter.sv
dv/tb.sv
